>>> src/cdbi_pkg.sv
// ----------------------------------------------------------------------------
// cdbi_pkg
// Types and constants shared by the display bus interface modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cdbi_pkg;

    localparam int          IDX_W      = 13;
    localparam logic [13:0] RAM_BASE   = 14'h2000;
    localparam logic [13:0] OFFSET_MASK = 14'h3FFF;

    localparam logic [1:0]  SIZE_BYTE  = 2'd1;
    localparam logic [1:0]  SIZE_WORD  = 2'd2;

    localparam logic [13:0] PORT_SEL_WORD  = 14'd0;
    localparam logic [13:0] PORT_SEL_BYTE  = 14'd1;
    localparam logic [13:0] PORT_DATA_WORD = 14'd2;
    localparam logic [13:0] PORT_DATA_BYTE = 14'd3;

    localparam logic [3:0]  REG_CURSOR_START = 4'd10;
    localparam logic [3:0]  REG_CURSOR_END   = 4'd11;
    localparam logic [3:0]  REG_START_HI     = 4'd12;
    localparam logic [3:0]  REG_START_LO     = 4'd13;
    localparam logic [3:0]  REG_CURSOR_HI    = 4'd14;
    localparam logic [3:0]  REG_CURSOR_LO    = 4'd15;

    localparam logic [1:0]  BLINK_STEADY = 2'd0;
    localparam logic [1:0]  BLINK_OFF    = 2'd1;
    localparam logic [1:0]  BLINK_FAST   = 2'd2;
    localparam logic [7:0]  MASK_STEADY  = 8'h00;
    localparam logic [7:0]  MASK_OFF     = 8'hFF;
    localparam logic [7:0]  MASK_FAST    = 8'h20;
    localparam logic [7:0]  MASK_SLOW    = 8'h10;

    // Scan line scale factor 23/13 as a reciprocal: floor(x * 23 / 13) is
    // exact for x below 64 with this 16-bit fraction.
    localparam logic [22:0] LINE_SCALE = 23'd115966;

    typedef enum logic [2:0] {
        CMD_ERROR  = 3'd0,
        CMD_RAM_RD = 3'd1,
        CMD_RAM_WR = 3'd2,
        CMD_SELECT = 3'd3,
        CMD_REG_WR = 3'd4,
        CMD_REG_RD = 3'd5
    } cdbi_kind_t;

    typedef struct packed {
        logic [0:0]  opcode;
        logic [15:0] offset;
        logic [1:0]  access_size;
        logic [15:0] write_data;
    } cdbi_req_t;

    typedef struct packed {
        logic        access_fault;
        logic [15:0] read_data;
        logic [13:0] screen_start;
        logic [13:0] screen_end;
        logic [13:0] cursor_address;
        logic [5:0]  cursor_top_line;
        logic [6:0]  cursor_bottom_line;
        logic [6:0]  cursor_rows;
        logic [7:0]  blink_mask;
        logic [7:0]  selected_register;
    } cdbi_rsp_t;

    typedef struct packed {
        cdbi_kind_t       kind;
        logic             word;
        logic [IDX_W-1:0] idx0;
        logic [IDX_W-1:0] idx1;
        logic [15:0]      data;
    } cdbi_cmd_t;

    typedef struct packed {
        logic             wr_en;
        logic             rd_en;
        logic [IDX_W-1:0] addr;
        logic [7:0]       wdata;
    } cdbi_ram_cmd_t;

    function automatic logic [6:0] scale_line(input logic [5:0] x);
        logic [22:0] prod;
        prod = {17'd0, x} * LINE_SCALE;
        return prod[22:16];
    endfunction

endpackage

`default_nettype wire

>>> src/cdbi_front.sv
// ----------------------------------------------------------------------------
// cdbi_front
// Accepts bus accesses and classifies them into commands for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cdbi_front #(
    parameter int ALPHA_BYTES = 4096
) (
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire cdbi_pkg::cdbi_req_t req,
    input  wire logic               ram_busy,
    input  wire logic               queue_full,
    output logic                    push,
    output cdbi_pkg::cdbi_cmd_t     push_cmd
);

    localparam logic [31:0] LIM_BYTE = 32'(32'h2000 + 2 * ALPHA_BYTES - 1);
    localparam logic [31:0] LIM_WORD = 32'(32'h2000 + 2 * ALPHA_BYTES - 2);
    localparam logic [13:0] DEPTH    = 14'(ALPHA_BYTES);

    logic [13:0] off;
    logic        is_byte;
    logic        is_word;
    logic        in_window;
    logic [13:0] rel;
    logic [13:0] i0;
    logic [13:0] i0_inc;
    logic [13:0] i1;

    assign req_ready = !ram_busy && !queue_full;
    assign push      = req_valid && req_ready;

    always_comb
    begin
        off       = req.offset[13:0] & cdbi_pkg::OFFSET_MASK;
        is_byte   = (req.access_size == cdbi_pkg::SIZE_BYTE);
        is_word   = (req.access_size == cdbi_pkg::SIZE_WORD);
        in_window = (off >= cdbi_pkg::RAM_BASE) &&
                    (32'(off) <= (is_word ? LIM_WORD : LIM_BYTE));
        rel       = off - cdbi_pkg::RAM_BASE;
        i0        = (rel >= DEPTH) ? (rel - DEPTH) : rel;
        i0_inc    = i0 + 14'd1;
        i1        = (i0_inc == DEPTH) ? 14'd0 : i0_inc;

        push_cmd.word = is_word;
        push_cmd.idx0 = i0[cdbi_pkg::IDX_W-1:0];
        push_cmd.idx1 = i1[cdbi_pkg::IDX_W-1:0];
        push_cmd.data = req.write_data;
        push_cmd.kind = cdbi_pkg::CMD_ERROR;

        if (is_byte || is_word)
        begin
            if (in_window)
            begin
                push_cmd.kind = req.opcode[0] ? cdbi_pkg::CMD_RAM_WR : cdbi_pkg::CMD_RAM_RD;
            end
            else if (req.opcode[0])
            begin
                if ((is_word && off == cdbi_pkg::PORT_SEL_WORD) ||
                    (is_byte && off == cdbi_pkg::PORT_SEL_BYTE))
                begin
                    push_cmd.kind = cdbi_pkg::CMD_SELECT;
                end
                else if ((is_word && off == cdbi_pkg::PORT_DATA_WORD) ||
                         (is_byte && off == cdbi_pkg::PORT_DATA_BYTE))
                begin
                    push_cmd.kind = cdbi_pkg::CMD_REG_WR;
                end
            end
            else if (is_byte && off == cdbi_pkg::PORT_DATA_BYTE)
            begin
                push_cmd.kind = cdbi_pkg::CMD_REG_RD;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/cdbi_cmd_queue.sv
// ----------------------------------------------------------------------------
// cdbi_cmd_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cdbi_cmd_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire cdbi_pkg::cdbi_cmd_t push_cmd,
    output logic                     full,
    input  wire logic                pop,
    output logic                     head_valid,
    output cdbi_pkg::cdbi_cmd_t      head_cmd
);

    cdbi_pkg::cdbi_cmd_t entry_reg [2];
    logic                wr_ptr_reg;
    logic                wr_ptr_next;
    logic                rd_ptr_reg;
    logic                rd_ptr_next;
    logic [1:0]          count_reg;
    logic [1:0]          count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

>>> src/cdbi_alpha_ram.sv
// ----------------------------------------------------------------------------
// cdbi_alpha_ram
// Single-port character RAM with registered read and a clearing sweep
// after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module cdbi_alpha_ram #(
    parameter int ALPHA_BYTES = 4096
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire cdbi_pkg::cdbi_ram_cmd_t ram_cmd,
    output logic [7:0]                   ram_q,
    output logic                         busy
);

    localparam int          AW   = $clog2(ALPHA_BYTES);
    localparam logic [AW-1:0] LAST = AW'(ALPHA_BYTES - 1);

    logic [7:0]    mem [ALPHA_BYTES];
    logic          clr_active_reg;
    logic          clr_active_next;
    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] clr_cnt_next;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    assign busy = clr_active_reg;

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_cnt_next    = clr_cnt_reg;
        if (clr_active_reg)
        begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == LAST)
            begin
                clr_active_next = 1'b0;
            end
        end
        wr_en   = clr_active_reg || ram_cmd.wr_en;
        wr_addr = clr_active_reg ? clr_cnt_reg : ram_cmd.addr[AW-1:0];
        wr_data = clr_active_reg ? 8'h00 : ram_cmd.wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_cnt_reg    <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ram_cmd.rd_en)
        begin
            ram_q <= mem[ram_cmd.addr[AW-1:0]];
        end
    end

endmodule

`default_nettype wire

>>> src/cdbi_back.sv
// ----------------------------------------------------------------------------
// cdbi_back
// Executes queued commands: RAM byte steps, controller register updates,
// derived cursor and screen values, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cdbi_back #(
    parameter int VISIBLE_CELLS = 2000
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                head_valid,
    input  wire cdbi_pkg::cdbi_cmd_t head_cmd,
    output logic                     pop,
    output cdbi_pkg::cdbi_ram_cmd_t  ram_cmd,
    input  wire logic [7:0]          ram_q,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output cdbi_pkg::cdbi_rsp_t      rsp
);

    localparam logic [13:0] VIS = 14'(VISIBLE_CELLS);

    logic                step_reg;
    logic                step_next;
    logic                is_ram;
    logic                last_step;
    logic                fire;
    logic                e2_move;
    logic                e2_free;

    logic [7:0]          reg_index_reg;
    logic [7:0]          reg_index_next;
    logic [7:0]          file_reg [16];
    logic [7:0]          file_next [16];
    logic [13:0]         start_reg;
    logic [13:0]         start_next;
    logic [13:0]         end_reg;
    logic [13:0]         end_next;
    logic [13:0]         cursor_reg;
    logic [13:0]         cursor_next;
    logic [5:0]          top_reg;
    logic [5:0]          top_next;
    logic [6:0]          bottom_reg;
    logic [6:0]          bottom_next;
    logic [6:0]          height_reg;
    logic [6:0]          height_next;
    logic [7:0]          blink_reg;
    logic [7:0]          blink_next;

    logic [7:0]          wr_val;
    logic                sel_ok;
    logic [3:0]          sel;
    logic                upd_height;
    logic [6:0]          top_scaled;
    logic [13:0]         new_start;
    logic [7:0]          reg_rd_val;

    logic                e2_valid_reg;
    logic                e2_valid_next;
    logic                e2_ram_rd_reg;
    logic                e2_word_reg;
    logic [7:0]          e2_hi_reg;
    cdbi_pkg::cdbi_rsp_t e2_rsp_reg;
    cdbi_pkg::cdbi_rsp_t e2_rsp_next;
    cdbi_pkg::cdbi_rsp_t e2_out;

    logic                out_valid_reg;
    logic                out_valid_next;
    cdbi_pkg::cdbi_rsp_t out_reg;

    assign is_ram    = (head_cmd.kind == cdbi_pkg::CMD_RAM_RD) ||
                       (head_cmd.kind == cdbi_pkg::CMD_RAM_WR);
    assign last_step = !(is_ram && head_cmd.word) || step_reg;
    assign e2_move   = e2_valid_reg && (!out_valid_reg || rsp_ready);
    assign e2_free   = !e2_valid_reg || e2_move;
    assign fire      = head_valid && e2_free;
    assign pop       = fire && last_step;
    assign step_next = fire ? !last_step : step_reg;

    always_comb
    begin
        ram_cmd.wr_en = fire && (head_cmd.kind == cdbi_pkg::CMD_RAM_WR);
        ram_cmd.rd_en = fire && (head_cmd.kind == cdbi_pkg::CMD_RAM_RD);
        ram_cmd.addr  = step_reg ? head_cmd.idx1 : head_cmd.idx0;
        ram_cmd.wdata = (head_cmd.word && !step_reg) ? head_cmd.data[15:8]
                                                     : head_cmd.data[7:0];
    end

    always_comb
    begin
        wr_val     = head_cmd.data[7:0];
        sel_ok     = (reg_index_reg[7:4] == 4'd0);
        sel        = reg_index_reg[3:0];
        reg_rd_val = sel_ok ? file_reg[sel] : 8'h00;
        upd_height = 1'b0;
        top_scaled = cdbi_pkg::scale_line({1'b0, wr_val[4:0]});

        reg_index_next = reg_index_reg;
        file_next      = file_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        cursor_next    = cursor_reg;
        top_next       = top_reg;
        bottom_next    = bottom_reg;
        height_next    = height_reg;
        blink_next     = blink_reg;

        case (head_cmd.kind)
            cdbi_pkg::CMD_SELECT:
            begin
                reg_index_next = wr_val;
            end
            cdbi_pkg::CMD_REG_WR:
            begin
                if (sel_ok)
                begin
                    file_next[sel] = wr_val;
                    case (sel)
                        cdbi_pkg::REG_CURSOR_START:
                        begin
                            top_next   = top_scaled[5:0];
                            upd_height = 1'b1;
                            case (wr_val[6:5])
                                cdbi_pkg::BLINK_STEADY: blink_next = cdbi_pkg::MASK_STEADY;
                                cdbi_pkg::BLINK_OFF:    blink_next = cdbi_pkg::MASK_OFF;
                                cdbi_pkg::BLINK_FAST:   blink_next = cdbi_pkg::MASK_FAST;
                                default:                blink_next = cdbi_pkg::MASK_SLOW;
                            endcase
                        end
                        cdbi_pkg::REG_CURSOR_END:
                        begin
                            bottom_next = cdbi_pkg::scale_line(wr_val[5:0]);
                            upd_height  = 1'b1;
                        end
                        cdbi_pkg::REG_START_HI, cdbi_pkg::REG_START_LO:
                        begin
                            new_start = {file_next[cdbi_pkg::REG_START_HI][5:0],
                                         file_next[cdbi_pkg::REG_START_LO]};
                            if (new_start != start_reg)
                            begin
                                start_next = new_start;
                                end_next   = new_start + VIS;
                            end
                        end
                        cdbi_pkg::REG_CURSOR_HI, cdbi_pkg::REG_CURSOR_LO:
                        begin
                            cursor_next = {file_next[cdbi_pkg::REG_CURSOR_HI][5:0],
                                           file_next[cdbi_pkg::REG_CURSOR_LO]};
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase

        new_start = {file_next[cdbi_pkg::REG_START_HI][5:0],
                     file_next[cdbi_pkg::REG_START_LO]};

        if (upd_height && (bottom_next >= {1'b0, top_next}))
        begin
            height_next = bottom_next - {1'b0, top_next} + 7'd1;
        end
    end

    always_comb
    begin
        e2_rsp_next.access_fault       = (head_cmd.kind == cdbi_pkg::CMD_ERROR);
        e2_rsp_next.read_data          = (head_cmd.kind == cdbi_pkg::CMD_REG_RD)
                                         ? {8'h00, reg_rd_val} : 16'h0000;
        e2_rsp_next.screen_start       = start_next;
        e2_rsp_next.screen_end         = end_next;
        e2_rsp_next.cursor_address     = cursor_next;
        e2_rsp_next.cursor_top_line    = top_next;
        e2_rsp_next.cursor_bottom_line = bottom_next;
        e2_rsp_next.cursor_rows        = height_next;
        e2_rsp_next.blink_mask         = blink_next;
        e2_rsp_next.selected_register  = reg_index_next;

        e2_out = e2_rsp_reg;
        if (e2_ram_rd_reg)
        begin
            e2_out.read_data = e2_word_reg ? {e2_hi_reg, ram_q} : {8'h00, ram_q};
        end

        e2_valid_next = pop ? 1'b1 : (e2_move ? 1'b0 : e2_valid_reg);
        out_valid_next = e2_move ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_reg);
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 1'b0;
            e2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            reg_index_reg <= 8'h00;
            start_reg     <= 14'd0;
            end_reg       <= 14'd0;
            cursor_reg    <= 14'd0;
            top_reg       <= 6'd0;
            bottom_reg    <= 7'd0;
            height_reg    <= 7'd0;
            blink_reg     <= 8'h00;
            for (int i = 0; i < 16; i++)
            begin
                file_reg[i] <= 8'h00;
            end
        end
        else
        begin
            step_reg      <= step_next;
            e2_valid_reg  <= e2_valid_next;
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                reg_index_reg <= reg_index_next;
                start_reg     <= start_next;
                end_reg       <= end_next;
                cursor_reg    <= cursor_next;
                top_reg       <= top_next;
                bottom_reg    <= bottom_next;
                height_reg    <= height_next;
                blink_reg     <= blink_next;
                file_reg      <= file_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            e2_rsp_reg    <= e2_rsp_next;
            e2_ram_rd_reg <= (head_cmd.kind == cdbi_pkg::CMD_RAM_RD);
            e2_word_reg   <= head_cmd.word;
        end
        if (fire && step_reg && (head_cmd.kind == cdbi_pkg::CMD_RAM_RD))
        begin
            e2_hi_reg <= ram_q;
        end
        if (e2_move)
        begin
            out_reg <= e2_out;
        end
    end

endmodule

`default_nettype wire

>>> src/crtc_display_bus_interface.sv
// ----------------------------------------------------------------------------
// crtc_display_bus_interface
// Character RAM and CRT controller register port on a display bus.
// ----------------------------------------------------------------------------
// Requests arrive on req (valid/ready), one bus access per beat; every access
// returns exactly one beat on rsp (valid/ready) carrying the bus error flag,
// the read data and the current cursor and screen values.
// An accepted access is registered in the command queue, then in the back-end
// stage, then in the result register, before it shows on rsp.
// Throughput is one byte access per cycle while rsp is not stalled; a RAM word
// access holds the back end while it steps through its two bytes, set by the
// single port of the character RAM, which touches one byte at a time.
// A two-entry command queue sits between the classifying front end and the
// executing back end, and a result register holds the finished beat, so new
// requests are still taken while rsp is stalled until the queue fills.
// After reset the character RAM is cleared one byte a cycle over all ALPHA_BYTES
// bytes, and req_ready stays low until the sweep is done.
// ----------------------------------------------------------------------------
`default_nettype none

module crtc_display_bus_interface #(
    parameter int ALPHA_BYTES   = 4096,
    parameter int VISIBLE_CELLS = 2000
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire cdbi_pkg::cdbi_req_t req,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output cdbi_pkg::cdbi_rsp_t      rsp
);

    logic                    ram_busy;
    logic                    queue_full;
    logic                    push;
    cdbi_pkg::cdbi_cmd_t     push_cmd;
    logic                    pop;
    logic                    head_valid;
    cdbi_pkg::cdbi_cmd_t     head_cmd;
    cdbi_pkg::cdbi_ram_cmd_t ram_cmd;
    logic [7:0]              ram_q;

    cdbi_front #(
        .ALPHA_BYTES (ALPHA_BYTES)
    ) u_front (
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .ram_busy   (ram_busy),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    cdbi_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    cdbi_alpha_ram #(
        .ALPHA_BYTES (ALPHA_BYTES)
    ) u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .ram_cmd (ram_cmd),
        .ram_q   (ram_q),
        .busy    (ram_busy)
    );

    cdbi_back #(
        .VISIBLE_CELLS (VISIBLE_CELLS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .ram_cmd    (ram_cmd),
        .ram_q      (ram_q),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire

>>> test/crtc_display_bus_interface_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crtc_display_bus_interface_tb
// Self-checking bench for the character RAM and CRT register bus port.
// ----------------------------------------------------------------------------
// A shadow copy of the character RAM, the register file and the derived cursor
// and screen values predicts every response beat. A short directed sequence
// hits the window edges, wrapping, the register port and the rejected cases.
// Random traffic of RAM accesses, select/write/read register sequences and
// unmapped noise follows. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------

module crtc_display_bus_interface_tb;

    localparam int ALPHA_BYTES   = 4096;
    localparam int VISIBLE_CELLS = 2000;
    localparam int TARGET_ITEMS  = 1050;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic       OP_READ    = 1'b0;
    localparam logic       OP_WRITE   = 1'b1;
    localparam logic [1:0] SIZE_NONE  = 2'd0;
    localparam logic [1:0] SIZE_THREE = 2'd3;

    class crtc_shadow;
        logic [7:0]          ram [ALPHA_BYTES];
        logic [7:0]          regs [16];
        logic [7:0]          sel_idx;
        logic [13:0]         start_addr;
        logic [13:0]         end_addr;
        logic [13:0]         cursor_pos;
        logic [5:0]          top_line;
        logic [6:0]          bottom_line;
        logic [6:0]          rows;
        logic [7:0]          blink;
        cdbi_pkg::cdbi_rsp_t pending_rsps [$];
        int                  mismatch_count;
        int                  beat_count;
        int                  ram_count;
        int                  port_count;
        int                  reject_count;

        function new();
            foreach (ram[i]) ram[i] = 8'h00;
            foreach (regs[i]) regs[i] = 8'h00;
            sel_idx        = 8'h00;
            start_addr     = '0;
            end_addr       = '0;
            cursor_pos     = '0;
            top_line       = '0;
            bottom_line    = '0;
            rows           = '0;
            blink          = 8'h00;
            mismatch_count = 0;
            beat_count     = 0;
            ram_count      = 0;
            port_count     = 0;
            reject_count   = 0;
        endfunction

        function void update_rows();
            if (bottom_line >= {1'b0, top_line})
                rows = 7'(bottom_line - top_line + 1);
        endfunction

        function void write_reg(logic [7:0] v);
            logic [13:0] new_start;
            if (sel_idx > 8'd15)
                return;
            regs[sel_idx[3:0]] = v;
            case (sel_idx[3:0])
                cdbi_pkg::REG_CURSOR_START:
                begin
                    top_line = 6'((int'(v & 8'h1F) * 23) / 13);
                    case (v[6:5])
                        cdbi_pkg::BLINK_STEADY: blink = cdbi_pkg::MASK_STEADY;
                        cdbi_pkg::BLINK_OFF:    blink = cdbi_pkg::MASK_OFF;
                        cdbi_pkg::BLINK_FAST:   blink = cdbi_pkg::MASK_FAST;
                        default:                blink = cdbi_pkg::MASK_SLOW;
                    endcase
                    update_rows();
                end
                cdbi_pkg::REG_CURSOR_END:
                begin
                    bottom_line = 7'((int'(v & 8'h3F) * 23) / 13);
                    update_rows();
                end
                cdbi_pkg::REG_START_HI, cdbi_pkg::REG_START_LO:
                begin
                    new_start = 14'({regs[cdbi_pkg::REG_START_HI],
                                     regs[cdbi_pkg::REG_START_LO]});
                    if (new_start != start_addr)
                    begin
                        start_addr = new_start;
                        end_addr   = 14'(int'(new_start) + VISIBLE_CELLS);
                    end
                end
                cdbi_pkg::REG_CURSOR_HI, cdbi_pkg::REG_CURSOR_LO:
                begin
                    cursor_pos = 14'({regs[cdbi_pkg::REG_CURSOR_HI],
                                      regs[cdbi_pkg::REG_CURSOR_LO]});
                end
                default: ;
            endcase
        endfunction

        function void note_access(cdbi_pkg::cdbi_req_t a);
            int                  off;
            int                  sz;
            int                  i0;
            int                  i1;
            logic [15:0]         rd;
            logic                err;
            cdbi_pkg::cdbi_rsp_t want;
            off = int'(a.offset[13:0]);
            sz  = int'(a.access_size);
            rd  = '0;
            err = 1'b1;
            if (a.access_size == cdbi_pkg::SIZE_BYTE || a.access_size == cdbi_pkg::SIZE_WORD)
            begin
                if (off >= int'(cdbi_pkg::RAM_BASE) &&
                    off <= int'(cdbi_pkg::RAM_BASE) + 2 * ALPHA_BYTES - sz)
                begin
                    i0  = (off - int'(cdbi_pkg::RAM_BASE)) % ALPHA_BYTES;
                    i1  = (i0 + 1) % ALPHA_BYTES;
                    err = 1'b0;
                    if (a.opcode == OP_WRITE)
                    begin
                        if (a.access_size == cdbi_pkg::SIZE_BYTE)
                        begin
                            ram[i0] = a.write_data[7:0];
                        end
                        else
                        begin
                            ram[i0] = a.write_data[15:8];
                            ram[i1] = a.write_data[7:0];
                        end
                    end
                    else if (a.access_size == cdbi_pkg::SIZE_BYTE)
                    begin
                        rd = {8'h00, ram[i0]};
                    end
                    else
                    begin
                        rd = {ram[i0], ram[i1]};
                    end
                end
                else if (a.opcode == OP_WRITE)
                begin
                    if ((a.access_size == cdbi_pkg::SIZE_WORD &&
                         off == int'(cdbi_pkg::PORT_SEL_WORD)) ||
                        (a.access_size == cdbi_pkg::SIZE_BYTE &&
                         off == int'(cdbi_pkg::PORT_SEL_BYTE)))
                    begin
                        sel_idx = a.write_data[7:0];
                        err     = 1'b0;
                    end
                    else if ((a.access_size == cdbi_pkg::SIZE_WORD &&
                              off == int'(cdbi_pkg::PORT_DATA_WORD)) ||
                             (a.access_size == cdbi_pkg::SIZE_BYTE &&
                              off == int'(cdbi_pkg::PORT_DATA_BYTE)))
                    begin
                        write_reg(a.write_data[7:0]);
                        err = 1'b0;
                    end
                end
                else if (a.access_size == cdbi_pkg::SIZE_BYTE &&
                         off == int'(cdbi_pkg::PORT_DATA_BYTE))
                begin
                    rd  = (sel_idx <= 8'd15) ? {8'h00, regs[sel_idx[3:0]]} : 16'h0000;
                    err = 1'b0;
                end
            end
            if (err)
                reject_count++;
            else if (off >= int'(cdbi_pkg::RAM_BASE))
                ram_count++;
            else
                port_count++;
            want.access_fault       = err;
            want.read_data          = rd;
            want.screen_start       = start_addr;
            want.screen_end         = end_addr;
            want.cursor_address     = cursor_pos;
            want.cursor_top_line    = top_line;
            want.cursor_bottom_line = bottom_line;
            want.cursor_rows        = rows;
            want.blink_mask         = blink;
            want.selected_register  = sel_idx;
            pending_rsps.push_back(want);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_beat(cdbi_pkg::cdbi_rsp_t got);
            cdbi_pkg::cdbi_rsp_t want;
            if (pending_rsps.size() == 0)
            begin
                $display("%0t: response beat with nothing expected, expected none actual %h",
                         $time, got);
                mismatch_count++;
                return;
            end
            want = pending_rsps.pop_front();
            beat_count++;
            compare_field("access_fault", 16'(want.access_fault), 16'(got.access_fault));
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("screen_start", 16'(want.screen_start), 16'(got.screen_start));
            compare_field("screen_end", 16'(want.screen_end), 16'(got.screen_end));
            compare_field("cursor_address", 16'(want.cursor_address),
                          16'(got.cursor_address));
            compare_field("cursor_top_line", 16'(want.cursor_top_line),
                          16'(got.cursor_top_line));
            compare_field("cursor_bottom_line", 16'(want.cursor_bottom_line),
                          16'(got.cursor_bottom_line));
            compare_field("cursor_rows", 16'(want.cursor_rows), 16'(got.cursor_rows));
            compare_field("blink_mask", 16'(want.blink_mask), 16'(got.blink_mask));
            compare_field("selected_register", 16'(want.selected_register),
                          16'(got.selected_register));
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_ready;
    cdbi_pkg::cdbi_req_t req;
    logic                rsp_valid;
    logic                rsp_ready;
    cdbi_pkg::cdbi_rsp_t rsp;

    crtc_shadow shadow = new();
    int         items_sent;
    int         cycle_count;
    bit         sender_pauses;
    bit         receiver_stalls;

    crtc_display_bus_interface #(
        .ALPHA_BYTES   (ALPHA_BYTES),
        .VISIBLE_CELLS (VISIBLE_CELLS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic cdbi_pkg::cdbi_req_t make_req(logic op, logic [15:0] off,
                                                     logic [1:0] sz, logic [15:0] data);
        cdbi_pkg::cdbi_req_t r;
        r.opcode      = op;
        r.offset      = off;
        r.access_size = sz;
        r.write_data  = data;
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with req_valid still high.
    task automatic send_access(input cdbi_pkg::cdbi_req_t a);
        int gap;
        gap = sender_pauses ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= a;
        do @(posedge clk); while (req_ready !== 1'b1);
        shadow.note_access(a);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_all_answered();
        req_valid <= 1'b0;
        while (shadow.pending_rsps.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [7:0] pick_reg_value();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'hC0;
            3:       return 8'h3F;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic random_accesses(input int count);
        int          stop_at;
        int          kind;
        logic [7:0]  idx;
        logic [12:0] low;
        logic [1:0]  sz;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 9)
            begin
                case ($urandom_range(0, 3))
                    0:       low = 13'($urandom_range(0, 31));
                    1:       low = 13'h1000 + 13'($urandom_range(0, 31));
                    2:       low = 13'h0FFE + 13'($urandom_range(0, 1)) +
                                   ($urandom_range(0, 1) ? 13'h1000 : 13'h0000);
                    default: low = 13'($urandom);
                endcase
                if ($urandom_range(0, 9) == 0)
                    sz = 2'($urandom_range(0, 3));
                else
                    sz = $urandom_range(0, 1) ? cdbi_pkg::SIZE_BYTE : cdbi_pkg::SIZE_WORD;
                send_access(make_req(1'($urandom), {2'($urandom), 1'b1, low}, sz,
                                     16'($urandom)));
            end
            else if (kind < 15)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: idx = 8'($urandom_range(10, 15));
                    6, 7:             idx = 8'($urandom_range(0, 15));
                    8:                idx = 8'($urandom_range(16, 255));
                    default:          idx = 8'($urandom);
                endcase
                if ($urandom_range(0, 1))
                    send_access(make_req(OP_WRITE, {2'b00, cdbi_pkg::PORT_SEL_WORD},
                                         cdbi_pkg::SIZE_WORD, {8'($urandom), idx}));
                else
                    send_access(make_req(OP_WRITE, {2'b00, cdbi_pkg::PORT_SEL_BYTE},
                                         cdbi_pkg::SIZE_BYTE, {8'($urandom), idx}));
                repeat ($urandom_range(1, 3))
                begin
                    case ($urandom_range(0, 2))
                        0: send_access(make_req(OP_WRITE, {2'b00, cdbi_pkg::PORT_DATA_WORD},
                                                cdbi_pkg::SIZE_WORD,
                                                {8'($urandom), pick_reg_value()}));
                        1: send_access(make_req(OP_WRITE, {2'b00, cdbi_pkg::PORT_DATA_BYTE},
                                                cdbi_pkg::SIZE_BYTE,
                                                {8'($urandom), pick_reg_value()}));
                        default: send_access(make_req(OP_READ,
                                                      {2'b00, cdbi_pkg::PORT_DATA_BYTE},
                                                      cdbi_pkg::SIZE_BYTE, 16'($urandom)));
                    endcase
                end
            end
            else if ($urandom_range(0, 1))
            begin
                send_access(make_req(1'($urandom), 16'($urandom), 2'($urandom_range(0, 3)),
                                     16'($urandom)));
            end
            else
            begin
                send_access(make_req(1'($urandom),
                                     {2'($urandom), 12'h000, 2'($urandom_range(0, 3))},
                                     2'($urandom_range(0, 3)), 16'($urandom)));
            end
        end
    endtask

    initial
    begin
        int stall;
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            stall = receiver_stalls ? $urandom_range(0, 7) : 0;
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (rsp_valid !== 1'b1);
            shadow.check_beat(rsp);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d beats outstanding.",
                 cycle_count, shadow.pending_rsps.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int blk;
        rst_n           = 1'b0;
        req_valid       = 1'b0;
        req             = '0;
        items_sent      = 0;
        sender_pauses   = 1'b1;
        receiver_stalls = 1'b1;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_access(make_req(OP_READ, 16'h2000, cdbi_pkg::SIZE_BYTE, 16'hFFFF));
        send_access(make_req(OP_WRITE, 16'h2FFF, cdbi_pkg::SIZE_WORD, 16'hA55A));
        send_access(make_req(OP_READ, 16'h2FFF, cdbi_pkg::SIZE_WORD, 16'h0000));
        send_access(make_req(OP_READ, 16'hE000, cdbi_pkg::SIZE_BYTE, 16'h0000));
        send_access(make_req(OP_WRITE, 16'h3FFF, cdbi_pkg::SIZE_BYTE, 16'hFF12));
        send_access(make_req(OP_READ, 16'h3FFF, cdbi_pkg::SIZE_WORD, 16'h0000));
        send_access(make_req(OP_WRITE, 16'h3FFF, cdbi_pkg::SIZE_WORD, 16'h1234));
        send_access(make_req(OP_READ, 16'h3FFE, cdbi_pkg::SIZE_WORD, 16'h0000));
        send_access(make_req(OP_WRITE, {2'b00, cdbi_pkg::PORT_SEL_WORD}, cdbi_pkg::SIZE_WORD,
                             {12'hFF0, cdbi_pkg::REG_START_HI}));
        send_access(make_req(OP_WRITE, {2'b00, cdbi_pkg::PORT_DATA_BYTE}, cdbi_pkg::SIZE_BYTE,
                             16'hFFC0));
        send_access(make_req(OP_WRITE, {2'b00, cdbi_pkg::PORT_DATA_WORD}, cdbi_pkg::SIZE_WORD,
                             16'h00FF));
        send_access(make_req(OP_READ, {2'b00, cdbi_pkg::PORT_DATA_BYTE}, cdbi_pkg::SIZE_BYTE,
                             16'h0000));
        send_access(make_req(OP_WRITE, {2'b00, cdbi_pkg::PORT_SEL_BYTE}, cdbi_pkg::SIZE_BYTE,
                             {12'hFF0, cdbi_pkg::REG_CURSOR_START}));
        send_access(make_req(OP_WRITE, {2'b00, cdbi_pkg::PORT_DATA_BYTE}, cdbi_pkg::SIZE_BYTE,
                             16'h007F));
        send_access(make_req(OP_WRITE, {2'b00, cdbi_pkg::PORT_SEL_BYTE}, cdbi_pkg::SIZE_BYTE,
                             {12'h000, cdbi_pkg::REG_CURSOR_END}));
        send_access(make_req(OP_WRITE, {2'b00, cdbi_pkg::PORT_DATA_WORD}, cdbi_pkg::SIZE_WORD,
                             16'hFF3F));
        send_access(make_req(OP_WRITE, {2'b00, cdbi_pkg::PORT_SEL_BYTE}, cdbi_pkg::SIZE_BYTE,
                             16'h0010));
        send_access(make_req(OP_WRITE, {2'b00, cdbi_pkg::PORT_DATA_BYTE}, cdbi_pkg::SIZE_BYTE,
                             16'h00AA));
        send_access(make_req(OP_READ, {2'b00, cdbi_pkg::PORT_DATA_BYTE}, cdbi_pkg::SIZE_BYTE,
                             16'h0000));
        send_access(make_req(OP_READ, {2'b00, cdbi_pkg::PORT_SEL_BYTE}, cdbi_pkg::SIZE_BYTE,
                             16'h0000));
        send_access(make_req(OP_WRITE, {2'b00, cdbi_pkg::PORT_SEL_WORD}, cdbi_pkg::SIZE_BYTE,
                             16'h000A));
        send_access(make_req(OP_READ, {2'b00, cdbi_pkg::PORT_DATA_BYTE}, cdbi_pkg::SIZE_WORD,
                             16'h0000));
        send_access(make_req(OP_READ, 16'h2000, SIZE_NONE, 16'h0000));
        send_access(make_req(OP_WRITE, 16'h2000, SIZE_THREE, 16'hFFFF));
        wait_all_answered();

        blk = 0;
        while (items_sent < TARGET_ITEMS)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    sender_pauses   = 1'b0;
                    receiver_stalls = 1'b0;
                end
                1:
                begin
                    sender_pauses   = 1'b1;
                    receiver_stalls = 1'b0;
                end
                2:
                begin
                    sender_pauses   = 1'b0;
                    receiver_stalls = 1'b1;
                end
                default:
                begin
                    sender_pauses   = 1'b1;
                    receiver_stalls = 1'b1;
                end
            endcase
            random_accesses(75);
            if (blk % 3 == 2)
                wait_all_answered();
            blk++;
        end

        wait_all_answered();
        repeat (16) @(posedge clk);
        if (shadow.pending_rsps.size() != 0)
        begin
            $display("%0t: outstanding beats expected 0 actual %0d",
                     $time, shadow.pending_rsps.size());
            shadow.mismatch_count++;
        end
        $display("Sent %0d accesses: %0d character RAM, %0d register port, %0d rejected.",
                 items_sent, shadow.ram_count, shadow.port_count, shadow.reject_count);
        $display("Checked %0d response beats, %0d mismatches.",
                 shadow.beat_count, shadow.mismatch_count);
        if (shadow.mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> crtc_display_bus_interface.f
src/cdbi_pkg.sv
src/cdbi_front.sv
src/cdbi_cmd_queue.sv
src/cdbi_alpha_ram.sv
src/cdbi_back.sv
src/crtc_display_bus_interface.sv
test/crtc_display_bus_interface_tb.sv
